### src/eftf_pkg.sv
package eftf_pkg;

    // Default sizes of the coordinate and edge-function datapaths.
    localparam int COORD_BITS_DEFAULT = 12;
    localparam int EDGE_BITS_DEFAULT  = 32;

    // Fixed field widths.
    localparam int CFG_W       = 12;
    localparam int CFG_INDEX_W = 1;
    localparam int PIX_W       = 11;
    localparam int COLOR_W     = 32;

    // Configuration register indexes and their reset values.
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]       FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0]       FRAME_HEIGHT_RESET = 12'd480;

    // Command codes carried by an input beat.
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Setup sequencer: six products, one accumulate trailing the last one.
    localparam int                STEP_W   = 3;
    localparam logic [STEP_W-1:0] MUL_LAST = 3'd6;

    // Term selects within one edge function.
    localparam logic TERM_ROW = 1'b0;
    localparam logic TERM_COL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BOX,
        ST_MUL,
        ST_RUN
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_vertices;
        logic       load_box;
        logic       mul_en;
        logic [1:0] mul_edge;
        logic       mul_term;
        logic       acc_en;
        logic [1:0] acc_edge;
        logic       acc_term;
        logic       pixel_step;
        logic       idle_result;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic box_empty;
        logic fin;
    } dp_status_t;

endpackage

### src/eftf_in_if.sv
interface eftf_in_if #(
    parameter int COORD_BITS = eftf_pkg::COORD_BITS_DEFAULT
);
    import eftf_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         command;
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic [COLOR_W-1:0]           fill_color;

    modport source (
        output valid, command, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, fill_color,
        input  ready
    );

    modport sink (
        input  valid, command, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, fill_color,
        output ready
    );
endinterface

### src/eftf_out_if.sv
interface eftf_out_if;
    import eftf_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic               covered;
    logic [COLOR_W-1:0] pixel_color;
    logic               last;
    logic               active;

    modport source (
        output valid, pixel_x, pixel_y, covered, pixel_color, last, active,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, covered, pixel_color, last, active,
        output ready
    );
endinterface

### src/eftf_ctrl.sv
module eftf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  logic                 job_command,
    output logic                 job_ready,
    output logic                 pixel_valid,
    input  logic                 pixel_ready,
    input  eftf_pkg::dp_status_t status,
    output eftf_pkg::dp_cmd_t    cmd
);
    import eftf_pkg::*;

    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] step_prev;
    logic              pixel_valid_reg;
    logic              pixel_valid_next;
    logic              job_accept;

    // Beats are taken only outside setup, and only when the result slot is free or draining.
    assign job_ready   = ((state_reg == ST_IDLE) || (state_reg == ST_RUN))
                         && (!pixel_valid_reg || pixel_ready);
    assign job_accept  = job_valid && job_ready;
    assign pixel_valid = pixel_valid_reg;
    assign step_prev   = step_reg - STEP_W'(1);

    // State, setup step counter and result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            pixel_valid_reg <= pixel_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        pixel_valid_next = pixel_valid_reg && !pixel_ready;
        cmd              = '0;

        unique case (state_reg)
            ST_IDLE, ST_RUN:
            begin
                if (job_accept)
                begin
                    if (job_command == CMD_START)
                    begin
                        cmd.load_vertices = 1'b1;
                        state_next        = ST_BOX;
                    end
                    else
                    begin
                        pixel_valid_next = 1'b1;
                        if (state_reg == ST_RUN)
                        begin
                            cmd.pixel_step = 1'b1;
                            if (status.fin)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.idle_result = 1'b1;
                        end
                    end
                end
            end

            ST_BOX:
            begin
                cmd.load_box = 1'b1;
                step_next    = '0;
                state_next   = status.box_empty ? ST_IDLE : ST_MUL;
            end

            ST_MUL:
            begin
                // Each step but the last starts one product; each step but the first folds in the one before it.
                cmd.mul_en   = (step_reg != MUL_LAST);
                cmd.mul_edge = step_reg[2:1];
                cmd.mul_term = step_reg[0];
                cmd.acc_en   = (step_reg != '0);
                cmd.acc_edge = step_prev[2:1];
                cmd.acc_term = step_prev[0];
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == MUL_LAST)
                begin
                    state_next = ST_RUN;
                end
            end
        endcase
    end

endmodule

### src/eftf_datapath.sv
module eftf_datapath #(
    parameter int COORD_BITS = eftf_pkg::COORD_BITS_DEFAULT,
    parameter int EDGE_BITS  = eftf_pkg::EDGE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [eftf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [eftf_pkg::CFG_W-1:0]          cfg_data,
    input  logic signed [COORD_BITS-1:0]        vertex_a_x,
    input  logic signed [COORD_BITS-1:0]        vertex_a_y,
    input  logic signed [COORD_BITS-1:0]        vertex_b_x,
    input  logic signed [COORD_BITS-1:0]        vertex_b_y,
    input  logic signed [COORD_BITS-1:0]        vertex_c_x,
    input  logic signed [COORD_BITS-1:0]        vertex_c_y,
    input  logic [eftf_pkg::COLOR_W-1:0]        fill_color,
    input  eftf_pkg::dp_cmd_t                   cmd,
    output eftf_pkg::dp_status_t                status,
    output logic [eftf_pkg::PIX_W-1:0]          pixel_x,
    output logic [eftf_pkg::PIX_W-1:0]          pixel_y,
    output logic                                covered,
    output logic [eftf_pkg::COLOR_W-1:0]        pixel_color,
    output logic                                last,
    output logic                                active
);
    import eftf_pkg::*;

    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int CUR_W      = COORD_BITS - 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int PROD_EXT_W = (PROD_W > EDGE_BITS) ? PROD_W : EDGE_BITS;
    localparam int CMP_W      = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 2;
    localparam int PIX_EXT_W  = (CUR_W > PIX_W) ? CUR_W : PIX_W;

    // Configuration.
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    // Latched triangle.
    logic signed [COORD_BITS-1:0] vx_reg [3];
    logic signed [COORD_BITS-1:0] vy_reg [3];
    logic [COLOR_W-1:0]           color_reg;

    // Box, deltas and edge functions.
    logic [CUR_W-1:0]         lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;
    logic signed [DIFF_W-1:0] dx_reg [3];
    logic signed [DIFF_W-1:0] dy_reg [3];
    logic signed [DIFF_W-1:0] dx_next [3];
    logic signed [DIFF_W-1:0] dy_next [3];
    logic [EDGE_BITS-1:0]     prod_reg;
    logic [EDGE_BITS-1:0]     prod_next;
    logic [EDGE_BITS-1:0]     edge_reg [3];
    logic [EDGE_BITS-1:0]     edge_step [3];

    // Raster cursor.
    logic [CUR_W-1:0] cursor_x_reg;
    logic [CUR_W-1:0] cursor_y_reg;
    logic             odd_row_reg;

    // Result payload.
    logic [PIX_W-1:0]   pixel_x_reg, pixel_y_reg;
    logic               covered_reg, last_reg, active_reg;
    logic [COLOR_W-1:0] pixel_color_reg;

    // Box logic.
    logic signed [COORD_BITS-1:0] min_x, max_x, min_y, max_y;
    logic signed [CMP_W-1:0]      lo_x_w, hi_x_w, lo_y_w, hi_y_w;
    logic signed [CMP_W-1:0]      min_x_w, max_x_w, min_y_w, max_y_w;
    logic signed [CMP_W-1:0]      fw_lim, fh_lim;

    // Multiplier operands.
    logic signed [COORD_BITS-1:0] sel_vx, sel_vy;
    logic signed [DIFF_W-1:0]     sel_dx, sel_dy;
    logic signed [DIFF_W-1:0]     mul_a, mul_b;
    logic signed [PROD_W-1:0]     prod_full;
    logic signed [PROD_EXT_W-1:0] prod_ext;

    // Pixel step.
    logic                 row_end;
    logic                 fin;
    logic                 cov;
    logic [PIX_EXT_W-1:0] cur_x_ext, cur_y_ext;

    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign covered     = covered_reg;
    assign pixel_color = pixel_color_reg;
    assign last        = last_reg;
    assign active      = active_reg;

    // Frame size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
            endcase
        end
    end

    // Bounding box clipped to the frame.
    always_comb
    begin
        min_x = vx_reg[0];
        max_x = vx_reg[0];
        min_y = vy_reg[0];
        max_y = vy_reg[0];
        for (int i = 1; i < 3; i++)
        begin
            if (vx_reg[i] < min_x) min_x = vx_reg[i];
            if (vx_reg[i] > max_x) max_x = vx_reg[i];
            if (vy_reg[i] < min_y) min_y = vy_reg[i];
            if (vy_reg[i] > max_y) max_y = vy_reg[i];
        end
        min_x_w = CMP_W'(min_x);
        max_x_w = CMP_W'(max_x);
        min_y_w = CMP_W'(min_y);
        max_y_w = CMP_W'(max_y);
        fw_lim  = $signed(CMP_W'(frame_width_reg)) - CMP_W'(1);
        fh_lim  = $signed(CMP_W'(frame_height_reg)) - CMP_W'(1);
        lo_x_w  = (min_x_w < 0) ? '0 : min_x_w;
        lo_y_w  = (min_y_w < 0) ? '0 : min_y_w;
        hi_x_w  = (max_x_w < fw_lim) ? max_x_w : fw_lim;
        hi_y_w  = (max_y_w < fh_lim) ? max_y_w : fh_lim;
    end

    assign status.box_empty = (lo_x_w > hi_x_w) || (lo_y_w > hi_y_w);

    // Edge deltas: edge i runs from vertex i to the next one around the triangle.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dx_next[i] = DIFF_W'(vx_reg[(i == 2) ? 0 : i + 1]) - DIFF_W'(vx_reg[i]);
            dy_next[i] = DIFF_W'(vy_reg[(i == 2) ? 0 : i + 1]) - DIFF_W'(vy_reg[i]);
        end
    end

    // Shared multiplier for the edge values at the box corner.
    always_comb
    begin
        unique case (cmd.mul_edge)
            2'd0:
            begin
                sel_vx = vx_reg[0];
                sel_vy = vy_reg[0];
                sel_dx = dx_reg[0];
                sel_dy = dy_reg[0];
            end
            2'd1:
            begin
                sel_vx = vx_reg[1];
                sel_vy = vy_reg[1];
                sel_dx = dx_reg[1];
                sel_dy = dy_reg[1];
            end
            default:
            begin
                sel_vx = vx_reg[2];
                sel_vy = vy_reg[2];
                sel_dx = dx_reg[2];
                sel_dy = dy_reg[2];
            end
        endcase

        if (cmd.mul_term == TERM_ROW)
        begin
            mul_a = $signed(DIFF_W'(lo_y_reg)) - DIFF_W'(sel_vy);
            mul_b = sel_dx;
        end
        else
        begin
            mul_a = $signed(DIFF_W'(lo_x_reg)) - DIFF_W'(sel_vx);
            mul_b = sel_dy;
        end
        prod_full = mul_a * mul_b;
        prod_ext  = PROD_EXT_W'(prod_full);
        prod_next = prod_ext[EDGE_BITS-1:0];
    end

    // Serpentine walk decisions and incremental edge updates.
    always_comb
    begin
        row_end = odd_row_reg ? (cursor_x_reg == lo_x_reg) : (cursor_x_reg == hi_x_reg);
        fin     = row_end && (cursor_y_reg == hi_y_reg);
        cov     = !edge_reg[0][EDGE_BITS-1] && !edge_reg[1][EDGE_BITS-1]
                  && !edge_reg[2][EDGE_BITS-1];
        for (int i = 0; i < 3; i++)
        begin
            if (row_end)
                edge_step[i] = edge_reg[i] + EDGE_BITS'(dx_reg[i]);
            else if (odd_row_reg)
                edge_step[i] = edge_reg[i] + EDGE_BITS'(dy_reg[i]);
            else
                edge_step[i] = edge_reg[i] - EDGE_BITS'(dy_reg[i]);
        end
        cur_x_ext = PIX_EXT_W'(cursor_x_reg);
        cur_y_ext = PIX_EXT_W'(cursor_y_reg);
    end

    assign status.fin = fin;

    // Triangle and box registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_vertices)
        begin
            vx_reg[0] <= vertex_a_x;
            vy_reg[0] <= vertex_a_y;
            vx_reg[1] <= vertex_b_x;
            vy_reg[1] <= vertex_b_y;
            vx_reg[2] <= vertex_c_x;
            vy_reg[2] <= vertex_c_y;
            color_reg <= fill_color;
        end
        if (cmd.load_box)
        begin
            lo_x_reg <= lo_x_w[CUR_W-1:0];
            hi_x_reg <= hi_x_w[CUR_W-1:0];
            lo_y_reg <= lo_y_w[CUR_W-1:0];
            hi_y_reg <= hi_y_w[CUR_W-1:0];
            for (int i = 0; i < 3; i++)
            begin
                dx_reg[i] <= dx_next[i];
                dy_reg[i] <= dy_next[i];
            end
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // Edge values: built up during setup, stepped per pixel.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cmd.acc_en && (cmd.acc_edge == 2'(i)))
            begin
                edge_reg[i] <= (cmd.acc_term == TERM_ROW) ? prod_reg : edge_reg[i] - prod_reg;
            end
            else if (cmd.pixel_step)
            begin
                edge_reg[i] <= edge_step[i];
            end
        end
    end

    // Cursor.
    always_ff @(posedge clk)
    begin
        if (cmd.load_box)
        begin
            cursor_x_reg <= lo_x_w[CUR_W-1:0];
            cursor_y_reg <= lo_y_w[CUR_W-1:0];
            odd_row_reg  <= 1'b0;
        end
        else if (cmd.pixel_step)
        begin
            if (!row_end)
            begin
                cursor_x_reg <= odd_row_reg ? cursor_x_reg - CUR_W'(1)
                                            : cursor_x_reg + CUR_W'(1);
            end
            else if (!fin)
            begin
                cursor_y_reg <= cursor_y_reg + CUR_W'(1);
                odd_row_reg  <= !odd_row_reg;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.pixel_step)
        begin
            pixel_x_reg     <= cur_x_ext[PIX_W-1:0];
            pixel_y_reg     <= cur_y_ext[PIX_W-1:0];
            covered_reg     <= cov;
            pixel_color_reg <= cov ? color_reg : '0;
            last_reg        <= fin;
            active_reg      <= 1'b1;
        end
        else if (cmd.idle_result)
        begin
            pixel_x_reg     <= '0;
            pixel_y_reg     <= '0;
            covered_reg     <= 1'b0;
            pixel_color_reg <= '0;
            last_reg        <= 1'b0;
            active_reg      <= 1'b0;
        end
    end

endmodule

### src/edge_function_triangle_fill_top.sv
// Channel  Direction  Beat contents
// -------  ---------  ---------------------------------------------------------------
// job      in         command, three vertices, fill color
// pixel    out        pixel_x, pixel_y, covered, pixel_color, last, active
// cfg      in         write enable, register index, write data (frame width, height)
//
// An advance beat's pixel is presented in the cycle after the beat is taken.
// A start beat holds job.ready low through setup: first the clipped box and deltas,
// then one shared multiplier forms the six corner products in turn; an empty box skips them.
// A new beat is taken while a pixel waits only if pixel.ready is high in that cycle.
// rst_n clears the sequencer and the pending pixel and restores a 640 x 480 frame.
module edge_function_triangle_fill_top #(
    parameter int COORD_BITS = eftf_pkg::COORD_BITS_DEFAULT,
    parameter int EDGE_BITS  = eftf_pkg::EDGE_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [eftf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [eftf_pkg::CFG_W-1:0]       cfg_data,
    eftf_in_if.sink                          job,
    eftf_out_if.source                       pixel
);
    import eftf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       job_accept;

    assign job_accept = job.valid && job.ready;

    // Sequencer and handshake control.
    eftf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job.valid),
        .job_command (job.command),
        .job_ready   (job.ready),
        .pixel_valid (pixel.valid),
        .pixel_ready (pixel.ready),
        .status      (status),
        .cmd         (cmd)
    );

    // Box setup, edge arithmetic and result register.
    eftf_datapath #(
        .COORD_BITS (COORD_BITS),
        .EDGE_BITS  (EDGE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .vertex_a_x  (job.vertex_a_x),
        .vertex_a_y  (job.vertex_a_y),
        .vertex_b_x  (job.vertex_b_x),
        .vertex_b_y  (job.vertex_b_y),
        .vertex_c_x  (job.vertex_c_x),
        .vertex_c_y  (job.vertex_c_y),
        .fill_color  (job.fill_color),
        .cmd         (cmd),
        .status      (status),
        .pixel_x     (pixel.pixel_x),
        .pixel_y     (pixel.pixel_y),
        .covered     (pixel.covered),
        .pixel_color (pixel.pixel_color),
        .last        (pixel.last),
        .active      (pixel.active)
    );

    // Setup blocks further beats right after a start beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_accept && (job.command == CMD_START) |=> !job.ready)
        else $error("job.ready high in the cycle after a start beat");

    // Every advance beat puts a pixel on the output in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_accept && (job.command == CMD_ADVANCE) |=> pixel.valid)
        else $error("advance beat did not produce a pixel");

    // A pixel with no triangle in progress carries all-zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && !pixel.active |-> (pixel.pixel_x == '0) && (pixel.pixel_y == '0)
            && !pixel.covered && (pixel.pixel_color == '0) && !pixel.last)
        else $error("idle pixel carries nonzero fields");

    // The final pixel of a box comes back to idle: no further pixel step until a new start.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pixel_step && status.fin |=> !cmd.pixel_step)
        else $error("pixel step issued after the final pixel of the box");

endmodule
